/* sv/mexp_pkg.sv */
`default_nettype none
package mexp_pkg;

    // operand and result width
    localparam int VALUE_WIDTH = 20;
    // bit counter of the serial multiplier, holds VALUE_WIDTH itself
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    // register index port width, wide enough to see writes past the list
    localparam int CFG_INDEX_WIDTH = 2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd1;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MULT,
        S_SQUARE,
        S_DONE
    } mexp_state_t;

    // request to the serial multiplier
    typedef struct packed {
        logic   start;
        value_t a;
        value_t b;
        value_t m;
    } mexp_mul_req_t;

    // response from the serial multiplier
    typedef struct packed {
        logic   done;
        value_t product;
    } mexp_mul_rsp_t;

endpackage
`default_nettype wire

/* sv/mexp_mulmod.sv */
`default_nettype none
// Bit-serial interleaved modular multiply: a * b mod m, one bit of a per cycle,
// MSB first. Requires b < m; a may be any value (used for base reduction with b = 1).
module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mexp_mul_req_t req,
    output mexp_mul_rsp_t      rsp
);

    localparam int EW = VALUE_WIDTH + 2;

    value_t               a_reg, a_next;
    value_t               b_reg, b_next;
    value_t               m_reg, m_next;
    value_t               r_reg, r_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [EW-1:0] t_sum;
    logic [EW-1:0] m_one;
    logic [EW-1:0] m_two;
    logic [EW-1:0] t_red;

    // r = 2r + a_i*b, then bring back below m (at most two subtracts, in parallel)
    always_comb
    begin
        t_sum = {1'b0, r_reg, 1'b0} + {2'b00, (a_reg[VALUE_WIDTH-1] ? b_reg : '0)};
        m_one = {2'b00, m_reg};
        m_two = {1'b0, m_reg, 1'b0};
        if (t_sum >= m_two)
            t_red = t_sum - m_two;
        else if (t_sum >= m_one)
            t_red = t_sum - m_one;
        else
            t_red = t_sum;
    end

    // load / iterate
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            r_next    = '0;
            cnt_next  = CNT_WIDTH'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[VALUE_WIDTH-2:0], 1'b0};
            r_next   = t_red[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial product registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule
`default_nettype wire

/* sv/modular_exponentiation.sv */
// Channel   Signals                              Direction  Moves
// input     in_valid, in_ready, base_value       in         one request: base to raise
// output    out_valid, out_ready, result_value   out        one result per request
// config    cfg_we, cfg_index, cfg_data          in         exponent [0], modulus [1]
//
// One request at a time. Each modular multiply is bit-serial in a shared unit:
// its product is taken when the unit raises done. Base reduction costs
// one multiply, then each exponent bit up to its highest set bit costs one squaring
// and one pass through the step state, plus one multiply when set. Exponent zero or
// modulus below two skip the multiplies and load the result from the done state.
// Reset clears the registers to exponent 0, modulus 2 and empties the block.
// A waiting result holds in the output register; the next request is taken
// meanwhile and its own result waits until the output register is free.
`default_nettype none
module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]     cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [VALUE_WIDTH-1:0]     base_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [VALUE_WIDTH-1:0]          result_value
);

    mexp_state_t state_reg, state_next;
    value_t      exp_reg;
    value_t      mod_reg;
    value_t      acc_reg, acc_next;
    value_t      sq_reg, sq_next;
    value_t      ebits_reg, ebits_next;
    value_t      result_reg, result_next;
    logic        out_valid_reg, out_valid_next;

    mexp_mul_req_t mul_req;
    mexp_mul_rsp_t mul_rsp;

    logic accept;
    logic mod_small;

    assign accept    = in_valid && in_ready;
    assign mod_small = (mod_reg[VALUE_WIDTH-1:1] == '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
            mod_reg <= VALUE_WIDTH'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXPONENT: exp_reg <= cfg_data;
                REG_MODULUS:  mod_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // square-and-multiply sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        ebits_next     = ebits_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = sq_reg;
        mul_req.b      = sq_reg;
        mul_req.m      = mod_reg;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ebits_next = exp_reg;
                    if (exp_reg == '0)
                    begin
                        acc_next   = VALUE_WIDTH'(1);
                        state_next = S_DONE;
                    end
                    else if (mod_small)
                    begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // base mod m as base * 1 mod m
                        acc_next      = VALUE_WIDTH'(1);
                        mul_req.start = 1'b1;
                        mul_req.a     = base_value;
                        mul_req.b     = VALUE_WIDTH'(1);
                        state_next    = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_rsp.product;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // no set bits left: the power is complete
                if (ebits_reg == '0)
                    state_next = S_DONE;
                else if (ebits_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = acc_reg;
                    state_next    = S_MULT;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_SQUARE;
                end
            end
            S_MULT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next      = mul_rsp.product;
                    mul_req.start = 1'b1;
                    state_next    = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_rsp.product;
                    ebits_next = {1'b0, ebits_reg[VALUE_WIDTH-1:1]};
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        ebits_reg  <= ebits_next;
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;

endmodule
`default_nettype wire

/* sv/mexp_checker.sv */
`default_nettype none
module mexp_checker
    import mexp_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cfg_we,
    input wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input wire logic [VALUE_WIDTH-1:0]     cfg_data,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic [VALUE_WIDTH-1:0]     base_value,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [VALUE_WIDTH-1:0]     result_value
);

    logic [2:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result changed or dropped while stalled");

    // a waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(base_value))
        else $error("request changed or dropped while waiting");

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after accepting a request");

    // at most one in work and one waiting at the output, no result without a request
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2 && (in_ready || pending_reg != 3'd0)
        && (!out_valid || pending_reg != 3'd0))
        else $error("outstanding request count out of range");

    // registers change only with nothing outstanding
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !$isunknown({cfg_index, cfg_data}) && pending_reg == 3'd0)
        else $error("configuration written while a request is outstanding");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .base_value   (base_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value)
);
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE3 = 2'd3;

    localparam value_t VALUE_MAX       = '1;
    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 50;
    localparam int     END_WAIT        = 1000;
    localparam int     WATCHDOG_LIMIT  = 20000;

    typedef enum logic {
        ROW_WRITE,
        ROW_BASE
    } row_kind_t;

    // one row of the directed table: a register write or a base to raise
    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_INDEX_WIDTH-1:0] index;
        value_t                     data;
        logic                       typed;
        value_t                     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 33;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset values: exponent 0, modulus 2
        '{ROW_BASE,  REG_EXPONENT, 20'h00000, 1'b1, 20'h00001},
        '{ROW_BASE,  REG_EXPONENT, 20'hFFFFF, 1'b1, 20'h00001},
        // modulus one
        '{ROW_WRITE, REG_EXPONENT, 20'd5,     1'b0, 20'h00000},
        '{ROW_WRITE, REG_MODULUS,  20'd1,     1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd7,     1'b1, 20'h00000},
        // modulus zero, no reduction
        '{ROW_WRITE, REG_MODULUS,  20'd0,     1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd123,   1'b1, 20'h00000},
        // exponent zero wins over modulus zero
        '{ROW_WRITE, REG_EXPONENT, 20'd0,     1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd5,     1'b1, 20'h00001},
        // all-ones registers
        '{ROW_WRITE, REG_MODULUS,  20'hFFFFF, 1'b0, 20'h00000},
        '{ROW_WRITE, REG_EXPONENT, 20'hFFFFF, 1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'h00000, 1'b1, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'h00001, 1'b1, 20'h00001},
        '{ROW_BASE,  REG_EXPONENT, 20'hFFFFF, 1'b1, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'hFFFFE, 1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'h55555, 1'b0, 20'h00000},
        // textbook key pair n = 61 * 53
        '{ROW_WRITE, REG_MODULUS,  20'd3233,  1'b0, 20'h00000},
        '{ROW_WRITE, REG_EXPONENT, 20'd17,    1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd65,    1'b1, 20'd2790},
        '{ROW_WRITE, REG_EXPONENT, 20'd2753,  1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd2790,  1'b1, 20'd65},
        // base above the modulus
        '{ROW_BASE,  REG_EXPONENT, 20'd6023,  1'b1, 20'd65},
        '{ROW_BASE,  REG_EXPONENT, 20'd3298,  1'b0, 20'h00000},
        // writes past the register list leave the key alone
        '{ROW_WRITE, REG_SPARE2,   20'h00000, 1'b0, 20'h00000},
        '{ROW_WRITE, REG_SPARE3,   20'hFFFFF, 1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd2790,  1'b1, 20'd65},
        // smallest legal modulus
        '{ROW_WRITE, REG_MODULUS,  20'd2,     1'b0, 20'h00000},
        '{ROW_WRITE, REG_EXPONENT, 20'd1,     1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'hAAAAA, 1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'h55555, 1'b0, 20'h00000},
        // only the top exponent bit set
        '{ROW_WRITE, REG_EXPONENT, 20'h80000, 1'b0, 20'h00000},
        '{ROW_WRITE, REG_MODULUS,  20'hFFFFE, 1'b0, 20'h00000},
        '{ROW_BASE,  REG_EXPONENT, 20'd3,     1'b0, 20'h00000}
    };

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    value_t                     cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    value_t                     base_value   = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    value_t                     result_value;

    // key as the block should hold it
    value_t exponent_reg = '0;
    value_t modulus_reg  = 20'd2;

    // powers still owed by the block, oldest first
    value_t pending_powers [$];
    value_t oldest_power;

    int  mismatches      = 0;
    int  quiet_cycles    = 0;
    int  stall_left      = 0;
    bit  sender_idles    = 1'b1;
    bit  receiver_stalls = 1'b1;

    modular_exponentiation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // base ** ex mod m by square-and-multiply
    function automatic value_t mod_power(value_t base, value_t ex, value_t m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        if (ex == '0)
            return value_t'(1);
        if (m < 2)
            return '0;
        m64 = 64'(m);
        sq  = 64'(base) % m64;
        acc = 64'd1;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (ex[i])
                acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return acc[VALUE_WIDTH-1:0];
    endfunction

    // base mix: anywhere, below the modulus, around it, tiny
    function automatic value_t pick_base(value_t m);
        case ($urandom_range(0, 5))
            1: return (m != '0) ? value_t'($urandom_range(0, m - 1)) : value_t'($urandom());
            2: return value_t'(m + value_t'($urandom_range(0, 2)) - value_t'(1));
            3: return value_t'($urandom_range(0, 3));
            default: return value_t'($urandom());
        endcase
    endfunction

    // hold requests back until every owed power has come
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_powers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input value_t data);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_EXPONENT)
            exponent_reg = data;
        else if (index == REG_MODULUS)
            modulus_reg = data;
        @(posedge clk);
    endtask

    task automatic send_base(input value_t base, input logic typed, input value_t want);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= base;
        do
            @(posedge clk);
        while (!in_ready);
        pending_powers.push_back(typed ? want : mod_power(base, exponent_reg, modulus_reg));
    endtask

    // receiver back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, result_value);
                mismatches++;
            end
            else
            begin
                oldest_power = pending_powers.pop_front();
                if (result_value !== oldest_power)
                begin
                    $display("%0t: result_value mismatch, expected %h, actual %h",
                             $time, oldest_power, result_value);
                    mismatches++;
                end
            end
        end

        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        value_t e;
        value_t m;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].index, directed_rows[r].data);
            else
                send_base(directed_rows[r].data, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // random phases, each under a fresh key
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 6))
                0:
                begin
                    e = value_t'($urandom_range(0, 15));
                    m = value_t'($urandom_range(2, VALUE_MAX));
                end
                1:
                begin
                    e = value_t'($urandom());
                    m = value_t'($urandom()) >> $urandom_range(0, 17);
                end
                2:
                begin
                    e = VALUE_MAX;
                    m = value_t'($urandom_range(2, VALUE_MAX));
                end
                3:
                begin
                    e = value_t'($urandom());
                    m = value_t'($urandom_range(2, 64));
                end
                4:
                begin
                    e = value_t'($urandom());
                    m = VALUE_MAX - value_t'($urandom_range(0, 1));
                end
                5:
                begin
                    e = value_t'(65537);
                    m = value_t'($urandom()) | value_t'(1);
                end
                default:
                begin
                    e = value_t'($urandom());
                    m = value_t'($urandom_range(0, 1));
                end
            endcase

            if ($urandom_range(0, 1))
            begin
                write_reg(REG_EXPONENT, e);
                write_reg(REG_MODULUS, m);
            end
            else
            begin
                write_reg(REG_MODULUS, m);
                write_reg(REG_EXPONENT, e);
            end

            // last phase runs flat out
            if (phase == PHASES - 1)
            begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles    = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 59) == 0)
                    wait_drain();
                send_base(pick_base(modulus_reg), 1'b0, '0);
            end
        end

        wait_drain();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
